// ----- src/sqb_pkg.sv -----
// Shared types, constants and state codes of the sprite quad batcher.
package sqb_pkg;

    localparam int MAX_QUADS_DEF     = 1024;
    localparam int TEX_SLOTS_DEF     = 32;
    localparam int SINE_ENTRIES_DEF  = 1024;

    localparam int SLOT_W   = 5;
    localparam int USED_W   = 6;
    localparam int QUAD_W   = 11;
    localparam int VIDX_W   = 12;
    localparam int TRIG_W   = 18;
    localparam int ANG_W    = 25;
    localparam int QUOT_W   = 13;
    localparam int PROD_W   = ANG_W + QUOT_W;

    // A full turn in Q16.16 is 45 << 19: drop the power of two, then divide by 45
    // with a reciprocal multiply that is exact for every index product.
    localparam int TURN_SH  = 19;
    localparam int DIVQ_W   = PROD_W - TURN_SH;
    localparam int RECIP_SH = 23;
    localparam int KPROD_W  = DIVQ_W + 18;
    localparam logic [17:0] RECIP_TURN = 18'd186414;

    localparam logic [13:0]      HI_OFFSET = 14'd4140;
    localparam logic [14:0]      RECIP_45  = 15'd23302;
    localparam logic [6:0]       TURN_HI   = 7'd45;

    typedef struct packed {
        logic signed [31:0]  pos_x;
        logic signed [31:0]  pos_y;
        logic signed [31:0]  pos_z;
        logic signed [31:0]  scale_x;
        logic signed [31:0]  scale_y;
        logic signed [31:0]  rotation_deg;
        logic signed [31:0]  corner_x;
        logic signed [31:0]  corner_y;
        logic [15:0]         coord_u;
        logic [15:0]         coord_v;
        logic [SLOT_W-1:0]   slot;
        logic                new_binding;
        logic [VIDX_W-1:0]   vertex_index;
        logic                batch_end;
        logic [QUAD_W-1:0]   batch_quads;
    } t_item;

    typedef enum logic [3:0] {
        B_IDLE,
        B_RED,
        B_MOD,
        B_MUL,
        B_DIV,
        B_ROM,
        B_ROT,
        B_SUM,
        B_SCL,
        B_OUT
    } t_bstate;

endpackage

// ----- src/sqb_front.sv -----
// Front end: texture slot lookup, corner and quad counting, batch end marking.
module sqb_front #(
    parameter int MAX_QUADS     = sqb_pkg::MAX_QUADS_DEF,
    parameter int TEXTURE_SLOTS = sqb_pkg::TEX_SLOTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_q_full,
    input  logic [31:0]          i_texture_id,
    input  logic                 i_scene_end,
    output logic                 o_push,
    output logic [sqb_pkg::SLOT_W-1:0] o_slot,
    output logic                 o_new,
    output logic [sqb_pkg::VIDX_W-1:0] o_vidx,
    output logic                 o_bend,
    output logic [sqb_pkg::QUAD_W-1:0] o_bquads
);
    localparam int IW = (TEXTURE_SLOTS > 1) ? $clog2(TEXTURE_SLOTS) : 1;

    logic [31:0]                 r_table [TEXTURE_SLOTS];
    logic [sqb_pkg::USED_W-1:0]  r_used, n_used;
    logic [sqb_pkg::QUAD_W-1:0]  r_quads, n_quads;
    logic [1:0]                  r_corner, n_corner;
    logic [sqb_pkg::SLOT_W-1:0]  r_held_slot, n_held_slot;
    logic                        r_held_new, n_held_new;
    logic                        w_hit, w_write;
    logic [sqb_pkg::SLOT_W-1:0]  w_found;
    logic [sqb_pkg::QUAD_W-1:0]  w_qnext;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        w_hit   = 1'b0;
        w_found = '0;
        for (int i = 0; i < TEXTURE_SLOTS; i++) begin
            if (!w_hit && (sqb_pkg::USED_W'(i) < r_used) && (r_table[i] == i_texture_id)) begin
                w_hit   = 1'b1;
                w_found = sqb_pkg::SLOT_W'(i);
            end
        end
    end

    always_comb begin
        n_used      = r_used;
        n_quads     = r_quads;
        n_corner    = r_corner + 2'd1;
        n_held_slot = r_held_slot;
        n_held_new  = r_held_new;
        w_write     = 1'b0;
        w_qnext     = r_quads + 1'b1;
        o_bend      = 1'b0;
        o_bquads    = '0;
        if (r_corner == 2'd0) begin
            if (w_hit) begin
                n_held_slot = w_found;
                n_held_new  = 1'b0;
            end else if (r_used < sqb_pkg::USED_W'(TEXTURE_SLOTS)) begin
                w_write     = 1'b1;
                n_held_slot = r_used[sqb_pkg::SLOT_W-1:0];
                n_held_new  = 1'b1;
                n_used      = r_used + 1'b1;
            end else begin
                n_held_slot = sqb_pkg::SLOT_W'(TEXTURE_SLOTS - 1);
                n_held_new  = 1'b0;
            end
        end
        if (r_corner == 2'd3) begin
            n_quads = w_qnext;
            if (w_qnext >= sqb_pkg::QUAD_W'(MAX_QUADS) ||
                r_used >= sqb_pkg::USED_W'(TEXTURE_SLOTS) || i_scene_end) begin
                o_bend   = 1'b1;
                o_bquads = w_qnext;
                n_quads  = '0;
                n_used   = '0;
            end
        end
        o_slot = n_held_slot;
        o_new  = n_held_new;
        o_vidx = {r_quads[sqb_pkg::VIDX_W-3:0], r_corner};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_quads     <= '0;
            r_corner    <= '0;
            r_held_slot <= '0;
            r_held_new  <= 1'b0;
        end else if (o_push) begin
            r_used      <= n_used;
            r_quads     <= n_quads;
            r_corner    <= n_corner;
            r_held_slot <= n_held_slot;
            r_held_new  <= n_held_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_push && w_write) begin
            r_table[r_used[IW-1:0]] <= i_texture_id;
        end
    end

endmodule

// ----- src/sqb_queue.sv -----
// Two-entry item queue between the front end and the transform back end.
module sqb_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sqb_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output sqb_pkg::t_item o_item
);
    sqb_pkg::t_item r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

endmodule

// ----- src/sqb_sine.sv -----
// Sine and cosine table in Q16.16, built from a Taylor series at elaboration.
module sqb_sine #(
    parameter int SINE_TABLE_ENTRIES = sqb_pkg::SINE_ENTRIES_DEF
) (
    input  logic                               i_clk,
    input  logic [$clog2(SINE_TABLE_ENTRIES)-1:0] i_k,
    output logic signed [sqb_pkg::TRIG_W-1:0]  o_s,
    output logic signed [sqb_pkg::TRIG_W-1:0]  o_c
);
    localparam longint unsigned Nl = longint'(SINE_TABLE_ENTRIES);
    localparam longint unsigned HalfPi = 64'd1686629713;
    localparam longint unsigned One = 64'd1 << 30;

    logic signed [sqb_pkg::TRIG_W-1:0] w_s [SINE_TABLE_ENTRIES];
    logic signed [sqb_pkg::TRIG_W-1:0] w_c [SINE_TABLE_ENTRIES];

    for (genvar g = 0; g < SINE_TABLE_ENTRIES; g++) begin : g_tab
        localparam longint unsigned K4  = longint'(g) * 4;
        localparam longint unsigned Q   = K4 / Nl;
        localparam longint unsigned R   = K4 - Q * Nl;
        localparam longint unsigned PHI = (R * HalfPi) / Nl;
        localparam longint unsigned X2  = (PHI * PHI) >> 30;
        localparam longint unsigned TS1 = ((PHI * X2) >> 30) / 6;
        localparam longint unsigned TC1 = ((One * X2) >> 30) / 2;
        localparam longint unsigned TS2 = ((TS1 * X2) >> 30) / 20;
        localparam longint unsigned TC2 = ((TC1 * X2) >> 30) / 12;
        localparam longint unsigned TS3 = ((TS2 * X2) >> 30) / 42;
        localparam longint unsigned TC3 = ((TC2 * X2) >> 30) / 30;
        localparam longint unsigned TS4 = ((TS3 * X2) >> 30) / 72;
        localparam longint unsigned TC4 = ((TC3 * X2) >> 30) / 56;
        localparam longint unsigned TS5 = ((TS4 * X2) >> 30) / 110;
        localparam longint unsigned TC5 = ((TC4 * X2) >> 30) / 90;
        localparam longint unsigned TS6 = ((TS5 * X2) >> 30) / 156;
        localparam longint unsigned TC6 = ((TC5 * X2) >> 30) / 132;
        localparam longint SS = longint'(PHI) - longint'(TS1) + longint'(TS2)
                              - longint'(TS3) + longint'(TS4) - longint'(TS5)
                              + longint'(TS6);
        localparam longint CS = longint'(One) - longint'(TC1) + longint'(TC2)
                              - longint'(TC3) + longint'(TC4) - longint'(TC5)
                              + longint'(TC6);
        localparam longint SV = (SS < 0) ? 64'sd0 : ((SS + 8192) >>> 14);
        localparam longint CV = (CS < 0) ? 64'sd0 : ((CS + 8192) >>> 14);
        localparam longint unsigned QQ = Q & 3;
        localparam longint SF = (QQ == 0) ? SV : (QQ == 1) ? CV : (QQ == 2) ? -SV : -CV;
        localparam longint CF = (QQ == 0) ? CV : (QQ == 1) ? -SV : (QQ == 2) ? -CV : SV;
        assign w_s[g] = sqb_pkg::TRIG_W'(SF);
        assign w_c[g] = sqb_pkg::TRIG_W'(CF);
    end

    always_ff @(posedge i_clk) begin
        o_s <= w_s[i_k];
        o_c <= w_c[i_k];
    end

endmodule

// ----- src/sqb_back.sv -----
// Back end: angle reduction, table index division, rotation and scaling.
module sqb_back #(
    parameter int SINE_TABLE_ENTRIES = sqb_pkg::SINE_ENTRIES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  sqb_pkg::t_item i_item,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output sqb_pkg::t_item o_item,
    output logic signed [31:0] o_world_x,
    output logic signed [31:0] o_world_y
);
    localparam int KW = $clog2(SINE_TABLE_ENTRIES);

    sqb_pkg::t_bstate r_state, n_state;
    sqb_pkg::t_item   r_item;
    logic [13:0]      w_hu;
    logic [27:0]      r_qprod;
    logic [sqb_pkg::ANG_W-1:0]  r_a;
    logic [sqb_pkg::DIVQ_W-1:0] r_hi;
    logic [sqb_pkg::QUOT_W-1:0] r_quot;
    logic [sqb_pkg::KPROD_W-1:0] w_kprod;
    logic [7:0]       w_qhi;
    logic [7:0]       w_m;
    logic [sqb_pkg::PROD_W-1:0] w_p;
    logic signed [sqb_pkg::TRIG_W-1:0] w_s, w_c;
    logic signed [49:0] r_pcx, r_pcy, r_psx, r_psy;
    logic signed [50:0] w_dx, w_dy;
    logic signed [31:0] r_rx, r_ry;
    logic signed [63:0] r_wx, r_wy;

    sqb_sine #(.SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)) u_sine (
        .i_clk (i_clk),
        .i_k   (r_quot[KW-1:0]),
        .o_s   (w_s),
        .o_c   (w_c)
    );

    assign w_hu   = {r_item.rotation_deg[31], r_item.rotation_deg[31:19]} + sqb_pkg::HI_OFFSET;
    assign w_qhi  = r_qprod[27:20];
    assign w_m    = 8'(w_hu - 14'(w_qhi * sqb_pkg::TURN_HI));
    assign w_p    = sqb_pkg::PROD_W'(r_a) * sqb_pkg::PROD_W'(SINE_TABLE_ENTRIES);
    assign w_kprod = sqb_pkg::KPROD_W'(r_hi) * sqb_pkg::KPROD_W'(sqb_pkg::RECIP_TURN);
    assign w_dx   = 51'(r_pcx) - 51'(r_pcy);
    assign w_dy   = 51'(r_psx) + 51'(r_psy);

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        unique case (r_state)
            sqb_pkg::B_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_state = sqb_pkg::B_RED;
                end
            end
            sqb_pkg::B_RED: n_state = sqb_pkg::B_MOD;
            sqb_pkg::B_MOD: n_state = sqb_pkg::B_MUL;
            sqb_pkg::B_MUL: n_state = sqb_pkg::B_DIV;
            sqb_pkg::B_DIV: n_state = sqb_pkg::B_ROM;
            sqb_pkg::B_ROM: n_state = sqb_pkg::B_ROT;
            sqb_pkg::B_ROT: n_state = sqb_pkg::B_SUM;
            sqb_pkg::B_SUM: n_state = sqb_pkg::B_SCL;
            sqb_pkg::B_SCL: n_state = sqb_pkg::B_OUT;
            sqb_pkg::B_OUT: begin
                if (!o_valid || i_ready) n_state = sqb_pkg::B_IDLE;
            end
            default: n_state = sqb_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sqb_pkg::B_IDLE;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == sqb_pkg::B_OUT && (!o_valid || i_ready)) o_valid <= 1'b1;
            else if (i_ready) o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            sqb_pkg::B_IDLE: if (i_q_valid) r_item <= i_item;
            sqb_pkg::B_RED:  r_qprod <= 28'(w_hu * sqb_pkg::RECIP_45);
            sqb_pkg::B_MOD: begin
                r_a <= {(w_m >= 8'(sqb_pkg::TURN_HI)) ? 6'(w_m - 8'(sqb_pkg::TURN_HI))
                                                      : w_m[5:0],
                        r_item.rotation_deg[18:0]};
            end
            sqb_pkg::B_MUL: begin
                r_hi <= w_p[sqb_pkg::PROD_W-1:sqb_pkg::TURN_SH];
            end
            sqb_pkg::B_DIV: begin
                r_quot <= w_kprod[sqb_pkg::RECIP_SH +: sqb_pkg::QUOT_W];
            end
            sqb_pkg::B_ROT: begin
                r_pcx <= w_c * r_item.corner_x;
                r_pcy <= w_s * r_item.corner_y;
                r_psx <= w_s * r_item.corner_x;
                r_psy <= w_c * r_item.corner_y;
            end
            sqb_pkg::B_SUM: begin
                r_rx <= w_dx[47:16];
                r_ry <= w_dy[47:16];
            end
            sqb_pkg::B_SCL: begin
                r_wx <= r_item.scale_x * r_rx;
                r_wy <= r_item.scale_y * r_ry;
            end
            sqb_pkg::B_OUT: begin
                if (!o_valid || i_ready) begin
                    o_item    <= r_item;
                    o_world_x <= r_item.pos_x + r_wx[47:16];
                    o_world_y <= r_item.pos_y + r_wy[47:16];
                end
            end
            default: ;
        endcase
    end

endmodule

// ----- src/sprite_quad_batcher.sv -----
// Top level of the sprite quad batcher: front end, item queue and transform back end.
//
// Input channel (i_in_valid / o_in_ready) takes one sprite corner per item, four
// corners per sprite. The texture id is looked up on the first corner and scene
// end is sampled on the fourth. Output channel (o_out_valid / i_out_ready) gives
// one world vertex per item with its slot, new-binding flag, vertex index and
// batch end marking.
// The front end classifies an item in the cycle it is accepted and pushes it into
// a two-entry queue; it stalls only when the queue is full.
// The back end works one item at a time: a pop in B_IDLE, angle reduction in
// B_RED and B_MOD, the index product, a reciprocal multiply for the sine table
// index, a registered table read, multiplies and adds in B_ROT, B_SUM and B_SCL
// and the output load in B_OUT. It pops the next item only after it has returned
// to B_IDLE, so it takes no new item while one is still in flight.
// Synchronous active-low reset clears the counters, the queue and the output
// valid; the slot table holds no reset and is only compared below the fill count.
// When the receiver stalls, the output register holds its item, the back end
// waits with the next one finished, and the queue fills before o_in_ready drops.
module sprite_quad_batcher #(
    parameter int MAX_QUADS          = sqb_pkg::MAX_QUADS_DEF,
    parameter int TEXTURE_SLOTS      = sqb_pkg::TEX_SLOTS_DEF,
    parameter int SINE_TABLE_ENTRIES = sqb_pkg::SINE_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_scale_x,
    input  logic signed [31:0] i_scale_y,
    input  logic signed [31:0] i_rotation_deg,
    input  logic [31:0]        i_texture_id,
    input  logic signed [31:0] i_corner_x,
    input  logic signed [31:0] i_corner_y,
    input  logic [15:0]        i_coord_u,
    input  logic [15:0]        i_coord_v,
    input  logic               i_scene_end,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_world_x,
    output logic signed [31:0] o_world_y,
    output logic signed [31:0] o_world_z,
    output logic [15:0]        o_out_u,
    output logic [15:0]        o_out_v,
    output logic [4:0]         o_slot,
    output logic               o_new_binding,
    output logic [11:0]        o_vertex_index,
    output logic               o_batch_end,
    output logic [10:0]        o_batch_quads
);
    logic           w_push, w_pop, w_q_full, w_q_valid;
    sqb_pkg::t_item w_in_item, w_q_item, w_out_item;
    logic [sqb_pkg::SLOT_W-1:0] w_slot;
    logic                       w_new, w_bend;
    logic [sqb_pkg::VIDX_W-1:0] w_vidx;
    logic [sqb_pkg::QUAD_W-1:0] w_bquads;

    // Classify the corner and advance the batch counters on accept.
    sqb_front #(
        .MAX_QUADS     (MAX_QUADS),
        .TEXTURE_SLOTS (TEXTURE_SLOTS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_q_full     (w_q_full),
        .i_texture_id (i_texture_id),
        .i_scene_end  (i_scene_end),
        .o_push       (w_push),
        .o_slot       (w_slot),
        .o_new        (w_new),
        .o_vidx       (w_vidx),
        .o_bend       (w_bend),
        .o_bquads     (w_bquads)
    );

    // Bundle the geometry with the front end's verdict.
    always_comb begin
        w_in_item.pos_x        = i_pos_x;
        w_in_item.pos_y        = i_pos_y;
        w_in_item.pos_z        = i_pos_z;
        w_in_item.scale_x      = i_scale_x;
        w_in_item.scale_y      = i_scale_y;
        w_in_item.rotation_deg = i_rotation_deg;
        w_in_item.corner_x     = i_corner_x;
        w_in_item.corner_y     = i_corner_y;
        w_in_item.coord_u      = i_coord_u;
        w_in_item.coord_v      = i_coord_v;
        w_in_item.slot         = w_slot;
        w_in_item.new_binding  = w_new;
        w_in_item.vertex_index = w_vidx;
        w_in_item.batch_end    = w_bend;
        w_in_item.batch_quads  = w_bquads;
    end

    sqb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    // Transform one queued item at a time into the output register.
    sqb_back #(
        .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_item    (w_q_item),
        .o_pop     (w_pop),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_item    (w_out_item),
        .o_world_x (o_world_x),
        .o_world_y (o_world_y)
    );

    assign o_world_z      = w_out_item.pos_z;
    assign o_out_u        = w_out_item.coord_u;
    assign o_out_v        = w_out_item.coord_v;
    assign o_slot         = w_out_item.slot;
    assign o_new_binding  = w_out_item.new_binding;
    assign o_vertex_index = w_out_item.vertex_index;
    assign o_batch_end    = w_out_item.batch_end;
    assign o_batch_quads  = w_out_item.batch_quads;

endmodule

// ----- src/sqb_checker.sv -----
// Port-level assertions for the sprite quad batcher, bound to the top level.
module sqb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_world_x,
    input logic [11:0] o_vertex_index,
    input logic        o_batch_end,
    input logic [10:0] o_batch_quads
);
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_quads_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_batch_end |-> o_batch_quads == 11'd0)
        else $error("batch quads outside batch end");

    a_end_on_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_batch_end |-> o_vertex_index[1:0] == 2'd3 && o_batch_quads != 11'd0)
        else $error("batch end not on a fourth corner");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_world_x))
        else $error("stalled item changed");

endmodule

bind sprite_quad_batcher sqb_checker u_sqb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_world_x      (o_world_x),
    .o_vertex_index (o_vertex_index),
    .o_batch_end    (o_batch_end),
    .o_batch_quads  (o_batch_quads)
);

// ----- dv/tb_sprite_quad_batcher.sv -----
// Self-checking testbench for the sprite quad batcher: vertex transform, slot table, batching.
module tb_sprite_quad_batcher;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_QUADS = sqb_pkg::MAX_QUADS_DEF;
    localparam int N_SLOTS = sqb_pkg::TEX_SLOTS_DEF;
    localparam int N_SINE  = sqb_pkg::SINE_ENTRIES_DEF;
    localparam longint TURN_Q16 = 64'd23592960;
    localparam longint HALF_PI  = 64'd1686629713;

    // One expected vertex, laid out as the output ports.
    typedef struct packed {
        logic [31:0] wx;
        logic [31:0] wy;
        logic [31:0] wz;
        logic [15:0] u;
        logic [15:0] v;
        logic [4:0]  slot;
        logic        nb;
        logic [11:0] vidx;
        logic        bend;
        logic [10:0] bq;
    } t_vertex;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic signed [31:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic signed [31:0] i_scale_x = '0, i_scale_y = '0, i_rotation_deg = '0;
    logic [31:0] i_texture_id = '0;
    logic signed [31:0] i_corner_x = '0, i_corner_y = '0;
    logic [15:0] i_coord_u = '0, i_coord_v = '0;
    logic i_scene_end = 1'b0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [31:0] o_world_x, o_world_y, o_world_z;
    logic [15:0] o_out_u, o_out_v;
    logic [4:0] o_slot;
    logic o_new_binding;
    logic [11:0] o_vertex_index;
    logic o_batch_end;
    logic [10:0] o_batch_quads;

    always #6 i_clk = ~i_clk;

    sprite_quad_batcher u_dut (.*);

    // Predictor state
    logic [31:0] tex_slots [N_SLOTS];
    int unsigned fill_cnt, quad_cnt, corner_pos, held_slot_q;
    logic held_new_q;

    t_vertex expected_vertices[$];
    int errors = 0;
    int n_sent = 0, n_checked = 0, n_batches = 0;
    int hold_off = 0;

    function automatic longint floor16(longint v);
        return v >>> 16;  // arithmetic shift floors
    endfunction

    function automatic longint wrap32(longint v);
        logic signed [31:0] t;
        t = v[31:0];
        return longint'(t);
    endfunction

    function automatic longint round_q30(longint v);
        if (v < 0) v = 0;
        return (v + 8192) >>> 14;
    endfunction

    // Sine and cosine of table entry k, in Q16.16
    task automatic sine_lookup(input int unsigned k, output longint s, output longint c);
        longint unsigned k4, q, r, phi, x2, ts, tc, d;
        longint ss, cs, sv, cv;
        k4 = longint'(k) * 4;
        q = k4 / N_SINE;
        r = k4 - q * N_SINE;
        phi = (r * HALF_PI) / N_SINE;
        x2 = (phi * phi) >> 30;
        ts = phi;
        tc = 64'd1 << 30;
        ss = phi;
        cs = 64'd1 << 30;
        for (int i = 1; i <= 6; i++) begin
            d = 2 * i;
            ts = ((ts * x2) >> 30) / (d * (d + 1));
            tc = ((tc * x2) >> 30) / ((d - 1) * d);
            if (i % 2) begin
                ss -= ts;
                cs -= tc;
            end else begin
                ss += ts;
                cs += tc;
            end
        end
        sv = round_q30(ss);
        cv = round_q30(cs);
        case (q % 4)
            0: begin s = sv;  c = cv;  end
            1: begin s = cv;  c = -sv; end
            2: begin s = -sv; c = -cv; end
            default: begin s = -cv; c = sv; end
        endcase
    endtask

    // Advance predictor state by one corner and queue the vertex it yields
    task automatic predict_vertex(input logic [31:0] f[9], input logic [15:0] u,
                                  input logic [15:0] v, input logic se);
        longint a, s, c, rx, ry, sx, sy, cx, cy;
        int unsigned k;
        bit hit;
        t_vertex e;
        a = longint'($signed(f[5])) % TURN_Q16;
        if (a < 0) a += TURN_Q16;
        k = (a * N_SINE) / TURN_Q16;
        sine_lookup(k, s, c);
        cx = longint'($signed(f[7]));
        cy = longint'($signed(f[8]));
        sx = longint'($signed(f[3]));
        sy = longint'($signed(f[4]));
        rx = wrap32(floor16(c * cx - s * cy));
        ry = wrap32(floor16(s * cx + c * cy));
        e.wx = 32'(longint'($signed(f[0])) + floor16(sx * rx));
        e.wy = 32'(longint'($signed(f[1])) + floor16(sy * ry));
        e.wz = f[2];
        e.u = u;
        e.v = v;
        if (corner_pos == 0) begin
            hit = 0;
            for (int i = 0; i < fill_cnt; i++) begin
                if (!hit && tex_slots[i] == f[6]) begin
                    hit = 1;
                    held_slot_q = i;
                end
            end
            if (hit) begin
                held_new_q = 0;
            end else if (fill_cnt < N_SLOTS) begin
                tex_slots[fill_cnt] = f[6];
                held_slot_q = fill_cnt;
                held_new_q = 1;
                fill_cnt++;
            end else begin
                held_slot_q = N_SLOTS - 1;
                held_new_q = 0;
            end
        end
        e.vidx = 12'(quad_cnt * 4 + corner_pos);
        e.bend = 0;
        e.bq = '0;
        if (corner_pos == 3) begin
            quad_cnt++;
            if (quad_cnt >= N_QUADS || fill_cnt >= N_SLOTS || se) begin
                e.bend = 1;
                e.bq = 11'(quad_cnt);
                quad_cnt = 0;
                fill_cnt = 0;
                n_batches++;
            end
            corner_pos = 0;
        end else begin
            corner_pos++;
        end
        e.slot = 5'(held_slot_q);
        e.nb = held_new_q;
        expected_vertices.push_back(e);
    endtask

    // Offer one corner, hold it until accepted, then predict it
    task automatic send_corner(input logic [31:0] f[9], input logic [15:0] u,
                               input logic [15:0] v, input logic se);
        i_in_valid <= 1'b1;
        i_pos_x <= f[0]; i_pos_y <= f[1]; i_pos_z <= f[2];
        i_scale_x <= f[3]; i_scale_y <= f[4]; i_rotation_deg <= f[5];
        i_texture_id <= f[6]; i_corner_x <= f[7]; i_corner_y <= f[8];
        i_coord_u <= u; i_coord_v <= v; i_scene_end <= se;
        do @(posedge i_clk); while (!o_in_ready);
        predict_vertex(f, u, v, se);
        n_sent++;
    endtask

    task automatic pause_sender(input int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Send one sprite of four corners; fld holds the shared fields, rest random
    task automatic send_sprite(input logic [31:0] fld[9], input logic se, input bit gaps);
        logic [31:0] f[9];
        logic [31:0] noise_tex;
        f = fld;
        for (int cn = 0; cn < 4; cn++) begin
            f[7] = (cn % 3 == 0) ? -fld[7] : fld[7];
            f[8] = (cn < 2) ? -fld[8] : fld[8];
            // texture id only counts on the first corner; scene end only on the last
            if (cn != 0) f[6] = $urandom;
            send_corner(f, 16'($urandom), 16'($urandom),
                        (cn == 3) ? se : 1'($urandom));
            if (gaps && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 8));
        end
    endtask

    function automatic logic [31:0] rand_small();
        return 32'($signed($urandom_range(0, 32'h40000)) - 32'sh20000);
    endfunction

    task automatic rand_fields(output logic [31:0] f[9], input int tex_pool);
        for (int i = 0; i < 9; i++) f[i] = rand_small();
        if ($urandom_range(0, 3) == 0) f[0] = $urandom;
        if ($urandom_range(0, 3) == 0) f[3] = $urandom;
        if ($urandom_range(0, 3) == 0) f[4] = $urandom;
        f[5] = ($urandom_range(0, 2) == 0) ? $urandom : 32'($urandom_range(0, 23592959));
        if ($urandom_range(0, 4) == 0) f[7] = $urandom;
        if ($urandom_range(0, 4) == 0) f[8] = $urandom;
        f[2] = $urandom;
        f[6] = (tex_pool > 0) ? 32'($urandom_range(0, tex_pool - 1)) : $urandom;
    endtask

    task automatic drain_all();
        i_in_valid <= 1'b0;
        while (expected_vertices.size() != 0) @(posedge i_clk);
    endtask

    // Extremes of every field, quadrant angles, negative and wrapping rotations
    task automatic test_directed();
        logic [31:0] f[9];
        logic [31:0] rots[6];
        rots = '{32'h0, 32'h005A_0000, 32'h00B4_0000, 32'h010E_0000,
                 32'h8000_0000, 32'hFFFF_FFFF};
        for (int r = 0; r < 6; r++) begin
            f = '{32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h0001_0000,
                  32'h0002_0000, rots[r], 32'(r), 32'h0000_8000, 32'h0000_4000};
            if (r == 4) f = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                              32'h8000_0000, rots[r], 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                              32'h8000_0000};
            if (r == 5) f = '{32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0,
                              rots[r], 32'h0, 32'hFFFF_FFFF, 32'h0};
            send_sprite(f, r == 5, 0);
        end
        drain_all();
    endtask

    // Fill every slot so the batch closes on a full table, then bind ids from it anew
    task automatic test_slot_fill();
        logic [31:0] f[9];
        for (int t = 0; t < N_SLOTS + 3; t++) begin
            rand_fields(f, 0);
            f[6] = 32'h1000 + 32'(t % (N_SLOTS + 1));
            send_sprite(f, 0, 1);
        end
        drain_all();
    endtask

    // Hold the receiver off while the sender keeps offering corners
    task automatic test_backpressure();
        logic [31:0] f[9];
        hold_off = 300;
        for (int t = 0; t < 6; t++) begin
            rand_fields(f, 8);
            send_sprite(f, t == 5, 0);
        end
        drain_all();
    endtask

    // Bursts of random sprites with a small texture pool so hits dominate
    task automatic test_random(input int n_sprites);
        logic [31:0] f[9];
        for (int t = 0; t < n_sprites; t++) begin
            rand_fields(f, ($urandom_range(0, 3) == 0) ? 0 : 12);
            send_sprite(f, $urandom_range(0, 9) == 0, 1);
            if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 30));
        end
        drain_all();
    endtask

    // Receiver: stall pattern of its own plus the long hold-off when requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_off > 0) begin
            i_out_ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            i_out_ready <= ($urandom_range(0, 63) < 40) ? 1'b1 : (($urandom_range(0, 3) == 0));
        end
    end

    // Compare each accepted vertex with the oldest prediction
    always @(posedge i_clk) begin
        t_vertex e, got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_world_x, o_world_y, o_world_z, o_out_u, o_out_v, o_slot,
                    o_new_binding, o_vertex_index, o_batch_end, o_batch_quads};
            if (expected_vertices.size() == 0) begin
                $display("%0t: vertex with none expected, got %h", $realtime, got);
                errors++;
            end else begin
                e = expected_vertices.pop_front();
                n_checked++;
                if (got !== e) begin
                    errors++;
                    $display("%0t: mismatch wx exp %h got %h, wy exp %h got %h, wz exp %h got %h",
                             $realtime, e.wx, got.wx, e.wy, got.wy, e.wz, got.wz);
                    $display("  u %h/%h v %h/%h slot %0d/%0d new %b/%b vidx %0d/%0d end %b/%b q %0d/%0d",
                             e.u, got.u, e.v, got.v, e.slot, got.slot, e.nb, got.nb,
                             e.vidx, got.vidx, e.bend, got.bend, e.bq, got.bq);
                end
            end
        end
    end

    initial begin
        #50ms;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        fill_cnt = 0; quad_cnt = 0; corner_pos = 0; held_slot_q = 0; held_new_q = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_slot_fill();
        test_backpressure();
        test_random(140);
        repeat (200) @(posedge i_clk);
        $display("Covered %0d corners, %0d vertices checked, %0d batches closed.",
                 n_sent, n_checked, n_batches);
        if (errors == 0 && expected_vertices.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
